// ===== sv/tlg_pkg.sv =====
// Shared types and constants for the toroidal Life generation engine.
// No dependencies; imported by every module of the block.
`default_nettype none

package tlg_pkg;

	// Fixed field widths of the command and result beats
	localparam int OP_W    = 2;
	localparam int ROW_W   = 5;
	localparam int COL_W   = 6;
	localparam int CNT_W   = 3;
	localparam int PHASE_W = 3;

	// Operation codes
	localparam logic [OP_W-1:0] OP_WRITE   = 2'd0;
	localparam logic [OP_W-1:0] OP_ADVANCE = 2'd1;
	localparam logic [OP_W-1:0] OP_READ    = 2'd2;

	// Consecutive equal snapshot checks that freeze the grid
	localparam logic [CNT_W-1:0] STABLE_LIMIT = 3'd4;

	// Controller states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SWEEP,
		ST_FINISH
	} tlg_state_t;

	// Control broadcast to every row cell
	typedef struct packed {
		logic             shift;  // rotate the ring by one row
		logic             copy;   // snapshot row takes grid row
		logic             wr;     // single-cell write (qualified per row by sel)
		logic             wval;   // value written
		logic [COL_W-1:0] col;    // column written
	} tlg_cell_ctrl_t;

endpackage

`default_nettype wire

// ===== sv/tlg_row_cell.sv =====
// One row cell of the grid ring: holds a grid row and its snapshot row.
// Depends on tlg_pkg for the control struct.
`default_nettype none

module tlg_row_cell #(
	parameter int COLS = 64
) (
	input  wire                     clk,
	input  wire                     arst_n,
	input  tlg_pkg::tlg_cell_ctrl_t ctrl,
	input  wire                     sel,
	input  wire  [COLS-1:0]         grid_in,
	input  wire  [COLS-1:0]         snap_in,
	output logic [COLS-1:0]         grid_q,
	output logic [COLS-1:0]         snap_q
);
	import tlg_pkg::*;

	localparam logic [COLS-1:0] ONE_COL = COLS'(1);

	logic [COLS-1:0] wmask;

	// column beyond the grid gives an empty mask
	assign wmask = ONE_COL << ctrl.col;

	// ring shift, snapshot copy or single-cell write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_q <= '0;
			snap_q <= '0;
		end else if (ctrl.shift) begin
			grid_q <= grid_in;
			snap_q <= snap_in;
		end else if (ctrl.copy) begin
			snap_q <= grid_q;
		end else if (ctrl.wr && sel) begin
			grid_q <= ctrl.wval ? (grid_q | wmask) : (grid_q & ~wmask);
		end
	end

endmodule

`default_nettype wire

// ===== sv/tlg_next_row.sv =====
// B3/S23 evaluator for one row, given the rows above and below, columns wrap.
// Depends on tlg_pkg only by convention; purely combinational.
`default_nettype none

module tlg_next_row #(
	parameter int COLS = 64
) (
	input  wire  [COLS-1:0] up,
	input  wire  [COLS-1:0] mid,
	input  wire  [COLS-1:0] dn,
	output logic [COLS-1:0] nxt
);
	import tlg_pkg::*;

	localparam logic [3:0] BIRTH   = 4'd3;
	localparam logic [3:0] SURVIVE = 4'd2;

	// one column evaluator per bit, neighbors taken with wrap-around
	for (genvar c = 0; c < COLS; c++) begin : g_col
		localparam int CL = (c + COLS - 1) % COLS;
		localparam int CR = (c + 1) % COLS;
		logic [3:0] n;
		assign n = 4'(up[CL]) + 4'(up[c]) + 4'(up[CR])
			+ 4'(mid[CL]) + 4'(mid[CR])
			+ 4'(dn[CL]) + 4'(dn[c]) + 4'(dn[CR]);
		assign nxt[c] = (n == BIRTH) || (mid[c] && (n == SURVIVE));
	end

endmodule

`default_nettype wire

// ===== sv/toroidal_life_generation_engine.sv =====
// Top level: controller plus a ring of row cells and the row evaluator.
// Depends on tlg_pkg, tlg_row_cell and tlg_next_row.
//
// A command beat is taken when start is high and busy is low. Write, read,
// the unused operation code and an advance while stable finish at once: busy
// stays low and done pulses in the next cycle, so these may be issued every
// cycle. An advance holds busy through the sweep and finish states, and done
// pulses once the finish state has passed: the grid rows sit in a ring of
// cells that rotates one row per cycle past a single next-row evaluator,
// and the finish state settles the snapshot check.
// Results cannot be held off; sample cell_out, similarity and stable in the
// cycle where done is high. cell_out is zero outside a read's result.
`default_nettype none

module toroidal_life_generation_engine #(
	parameter int ROWS = 32,
	parameter int COLS = 64
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          start,
	output logic                         busy,
	input  wire  [tlg_pkg::OP_W-1:0]     operation,
	input  wire  [tlg_pkg::ROW_W-1:0]    row,
	input  wire  [tlg_pkg::COL_W-1:0]    column,
	input  wire                          cell_in,
	output logic                         done,
	output logic                         cell_out,
	output logic [tlg_pkg::CNT_W-1:0]    similarity,
	output logic                         stable
);
	import tlg_pkg::*;

	localparam int SW = $clog2(ROWS);
	localparam logic [COLS-1:0] ONE_COL = COLS'(1);

	tlg_state_t     state_q, state_d;
	tlg_cell_ctrl_t cell_ctrl;

	logic [SW-1:0]      step_q;
	logic [PHASE_W-1:0] phase_q;
	logic [CNT_W-1:0]   count_q;
	logic               eq_q;
	logic               done_q;
	logic               cell_out_q;
	logic [COLS-1:0]    prev_q;
	logic [COLS-1:0]    first_q;

	logic [COLS-1:0] grid_row [ROWS];
	logic [COLS-1:0] snap_row [ROWS];
	logic [COLS-1:0] grid_nx  [ROWS];
	logic [COLS-1:0] snap_nx  [ROWS];
	logic [ROWS-1:0] row_hit;

	logic            accept;
	logic            stable_w;
	logic            last_step;
	logic            sweep_go;
	logic            finish;
	logic            quick_done;
	logic [COLS-1:0] win_up, win_dn, new_row, rd_row;
	logic            rd_bit;

	assign accept    = start && !busy;
	assign stable_w  = (count_q >= STABLE_LIMIT);
	assign last_step = (step_q == SW'(ROWS - 1));

	// row decode; rows beyond the grid never hit
	for (genvar g = 0; g < ROWS; g++) begin : g_hit
		assign row_hit[g] = (int'(row) == g);
	end

	// ring wiring: grid rows move toward cell 0, the new row enters at the tail
	for (genvar g = 0; g < ROWS; g++) begin : g_ring
		if (g == ROWS - 1) begin : g_tail
			assign grid_nx[g] = new_row;
			assign snap_nx[g] = snap_row[0];
		end else begin : g_body
			assign grid_nx[g] = grid_row[g+1];
			assign snap_nx[g] = snap_row[g+1];
		end
		tlg_row_cell #(.COLS(COLS)) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctrl    (cell_ctrl),
			.sel     (row_hit[g]),
			.grid_in (grid_nx[g]),
			.snap_in (snap_nx[g]),
			.grid_q  (grid_row[g]),
			.snap_q  (snap_row[g])
		);
	end

	// window around the head row; old neighbors that the ring has overwritten
	// come from prev_q and first_q
	assign win_up = (step_q == '0) ? grid_row[ROWS-1] : prev_q;
	assign win_dn = last_step ? first_q : grid_row[1];

	tlg_next_row #(.COLS(COLS)) u_rule (
		.up  (win_up),
		.mid (grid_row[0]),
		.dn  (win_dn),
		.nxt (new_row)
	);

	// read path: row select then column select
	always_comb begin
		rd_row = '0;
		for (int i = 0; i < ROWS; i++) begin
			rd_row = rd_row | (row_hit[i] ? grid_row[i] : '0);
		end
	end
	assign rd_bit = |(rd_row & (ONE_COL << column));

	// next state and cell control
	always_comb begin
		state_d        = state_q;
		cell_ctrl      = '0;
		cell_ctrl.wval = cell_in;
		cell_ctrl.col  = column;
		sweep_go       = 1'b0;
		finish         = 1'b0;
		quick_done     = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if ((operation == OP_ADVANCE) && !stable_w) begin
						state_d  = ST_SWEEP;
						sweep_go = 1'b1;
					end else begin
						quick_done   = 1'b1;
						cell_ctrl.wr = (operation == OP_WRITE);
					end
				end
			end
			ST_SWEEP: begin
				cell_ctrl.shift = 1'b1;
				if (last_step) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				finish         = 1'b1;
				cell_ctrl.copy = (phase_q == '0) && !eq_q;
				state_d        = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// sweep bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			eq_q   <= 1'b1;
		end else if (sweep_go) begin
			step_q <= '0;
			eq_q   <= 1'b1;
		end else if (cell_ctrl.shift) begin
			step_q <= step_q + SW'(1);
			eq_q   <= eq_q && (new_row == snap_row[0]);
		end
	end

	// saved old rows for the window
	always_ff @(posedge clk) begin
		if (cell_ctrl.shift) begin
			prev_q <= grid_row[0];
			if (step_q == '0) begin
				first_q <= grid_row[0];
			end
		end
	end

	// generation phase and stability count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
			count_q <= '0;
		end else if (finish) begin
			phase_q <= phase_q + PHASE_W'(1);
			if (phase_q == '0) begin
				if (!eq_q) begin
					count_q <= '0;
				end else if (count_q < STABLE_LIMIT) begin
					count_q <= count_q + CNT_W'(1);
				end
			end
		end
	end

	// result beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q     <= 1'b0;
			cell_out_q <= 1'b0;
		end else begin
			done_q     <= quick_done || finish;
			cell_out_q <= quick_done && (operation == OP_READ) && rd_bit;
		end
	end

	assign busy       = (state_q != ST_IDLE);
	assign done       = done_q;
	assign cell_out   = cell_out_q;
	assign similarity = count_q;
	assign stable     = stable_w;

endmodule

`default_nettype wire

// ===== sv/tlg_checker.sv =====
// Port-level checks for the toroidal Life generation engine, bound to the top.
// Depends on tlg_pkg and toroidal_life_generation_engine.
`default_nettype none

module tlg_port_checks (
	input wire                       clk,
	input wire                       arst_n,
	input wire                       start,
	input wire                       busy,
	input wire [tlg_pkg::OP_W-1:0]   operation,
	input wire [tlg_pkg::ROW_W-1:0]  row,
	input wire [tlg_pkg::COL_W-1:0]  column,
	input wire                       cell_in,
	input wire                       done,
	input wire                       cell_out,
	input wire [tlg_pkg::CNT_W-1:0]  similarity,
	input wire                       stable
);
	import tlg_pkg::*;

	// stable mirrors a saturated count
	a_stable_count: assert property (@(posedge clk) disable iff (!arst_n)
		stable == (similarity == STABLE_LIMIT))
		else $error("stable flag disagrees with similarity");

	// anything but a live advance completes with done in the next cycle
	a_quick_done: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && ((operation != OP_ADVANCE) || stable)) |=> (done && !busy))
		else $error("single-cycle command did not complete");

	// a live advance starts a sweep
	a_sweep_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (operation == OP_ADVANCE) && !stable) |=> (busy && !done))
		else $error("advance did not enter the sweep");

	// count only moves with a result beat
	a_count_moves: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(similarity) |-> done)
		else $error("similarity changed outside a result beat");

	// cell_out is quiet between result beats
	a_cell_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		!done |-> !cell_out)
		else $error("cell_out high without a result beat");

endmodule

bind toroidal_life_generation_engine tlg_port_checks u_tlg_port_checks (.*);

`default_nettype wire
